>>> sv/lwcg_pkg.sv
// Shared types, constants and register codes for the LCD window command generator.
package lwcg_pkg;

  localparam logic [15:0] PanelHeight = 16'd320;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [1:0] CFG_ROTATION   = 2'd0;
  localparam logic [1:0] CFG_COL_OFFSET = 2'd1;
  localparam logic [1:0] CFG_ROW_OFFSET = 2'd2;

  localparam logic [15:0] CMD_HSTART    = 16'h0406;
  localparam logic [15:0] CMD_HEND      = 16'h0407;
  localparam logic [15:0] CMD_HPOS      = 16'h0200;
  localparam logic [15:0] CMD_VSTART    = 16'h0408;
  localparam logic [15:0] CMD_VEND      = 16'h0409;
  localparam logic [15:0] CMD_VPOS      = 16'h0201;
  localparam logic [15:0] CMD_RAM_WRITE = 16'h0202;

  localparam logic [1:0] SEL_START = 2'd0;
  localparam logic [1:0] SEL_END   = 2'd1;
  localparam logic [1:0] SEL_POS   = 2'd2;

  localparam logic [2:0] LAST_IDX = 3'd5;

  typedef struct packed {
    logic [9:0]  win_x;
    logic [9:0]  win_y;
    logic [10:0] win_width;
    logic [10:0] win_height;
  } win_req_t;

  typedef struct packed {
    logic        is_command;
    logic [15:0] bus_word;
    logic        last_word;
  } bus_beat_t;

  typedef struct packed {
    logic        use_0408;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] p;
  } axis_job_t;

  typedef struct packed {
    logic      col_chg;
    logic      row_chg;
    axis_job_t col;
    axis_job_t row;
  } win_job_t;

  typedef enum logic [1:0] {
    ST_COL,
    ST_ROW,
    ST_RAM
  } back_state_e;

endpackage

>>> sv/lcd_window_command_generator_top.sv
// Top level of the LCD window command generator.
//
// Input channel: a window request (x, y, width, height) on req_i is taken
// when push is high and full is low. Output channel: the oldest bus beat
// sits on res_o while empty is low and is taken when pop is high.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (rotation, column offset, row offset); write only while idle.
// Each request yields 1, 7 or 13 beats: six per changed column or row pair,
// then the closing RAM-write command flagged by last_word.
// The first beat of a request passes the job queue, then the output register.
// Throughput: one beat per cycle from the back sequencer while pop is high
// or the output register is empty; a two-entry job queue lets the front
// keep taking requests while the back drains.
// Reset clears configuration to zero, empties queue and output register,
// and sets the pair cache so the first request writes both pairs.
// A stalled receiver holds the current beat; the queue then fills and
// full rises until pop resumes.
module lcd_window_command_generator_top import lwcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  win_req_t   req_i,
  input  logic       pop,
  output logic       empty,
  output bus_beat_t  res_o
);

  win_job_t job_in, job_out;
  logic     q_full, q_empty, q_pop, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  lwcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (req_i),
    .job_o       (job_in)
  );

  lwcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (job_in),
    .rd_i    (q_pop),
    .rdata_o (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lwcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res_o)
  );

endmodule

>>> sv/lwcg_front.sv
// Front part: configuration registers, pair cache and window address arithmetic.
module lwcg_front import lwcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  win_req_t   req_i,
  output win_job_t   job_o
);

  logic [1:0]  rotation_q;
  logic [7:0]  col_off_q;
  logic [7:0]  row_off_q;
  logic [10:0] cx_q, cx_d;
  logic [11:0] cw_q, cw_d;
  logic [10:0] cy_q, cy_d;
  logic [11:0] ch_q, ch_d;

  logic        landscape;
  logic        col_mirror;
  logic        row_mirror;
  logic [15:0] x16, y16, w16, h16, co16, ro16;
  logic [15:0] col_a, col_b, row_a, row_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= '0;
      col_off_q  <= '0;
      row_off_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION:   rotation_q <= cfg_wdata_i[1:0];
        CFG_COL_OFFSET: col_off_q  <= cfg_wdata_i;
        CFG_ROW_OFFSET: row_off_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '1;
      cw_q <= '1;
      cy_q <= '1;
      ch_q <= '1;
    end else begin
      cx_q <= cx_d;
      cw_q <= cw_d;
      cy_q <= cy_d;
      ch_q <= ch_d;
    end
  end

  always_comb begin
    x16  = {6'd0, req_i.win_x};
    y16  = {6'd0, req_i.win_y};
    w16  = {5'd0, req_i.win_width};
    h16  = {5'd0, req_i.win_height};
    co16 = {8'd0, col_off_q};
    ro16 = {8'd0, row_off_q};

    landscape  = rotation_q[0];
    col_mirror = (rotation_q == 2'd1);
    row_mirror = (rotation_q == 2'd0);

    job_o.col_chg = ({1'b0, req_i.win_x} != cx_q) || ({1'b0, req_i.win_width} != cw_q);
    job_o.row_chg = ({1'b0, req_i.win_y} != cy_q) || ({1'b0, req_i.win_height} != ch_q);

    col_a = col_mirror ? (PanelHeight - x16 - co16) : (x16 + co16);
    row_a = row_mirror ? (PanelHeight - y16 - ro16) : (y16 + ro16);
    col_b = col_mirror ? (col_a - w16) : (col_a + w16 - 16'd1);
    row_b = row_mirror ? (row_a - h16) : (row_a + h16 - 16'd1);

    job_o.col.use_0408 = landscape;
    job_o.col.s = col_mirror ? col_b : col_a;
    job_o.col.e = col_mirror ? (col_a - 16'd1) : col_b;
    job_o.col.p = col_mirror ? (col_a - 16'd1) : col_a;

    job_o.row.use_0408 = !landscape;
    job_o.row.s = row_mirror ? row_b : row_a;
    job_o.row.e = row_mirror ? (row_a - 16'd1) : row_b;
    job_o.row.p = row_mirror ? (row_a - 16'd1) : row_a;

    cx_d = cx_q;
    cw_d = cw_q;
    cy_d = cy_q;
    ch_d = ch_q;
    if (accept_i) begin
      cx_d = {1'b0, req_i.win_x};
      cw_d = {1'b0, req_i.win_width};
      cy_d = {1'b0, req_i.win_y};
      ch_d = {1'b0, req_i.win_height};
    end
  end

endmodule

>>> sv/lwcg_fifo.sv
// Short job queue between the front and back parts.
module lwcg_fifo import lwcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  win_job_t wdata_i,
  input  logic     rd_i,
  output win_job_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  win_job_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic                  do_wr, do_rd;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/lwcg_back.sv
// Back part: word sequencer and output register towards the panel bus.
module lwcg_back import lwcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  win_job_t  job_i,
  output logic      job_pop_o,
  input  logic      pop,
  output logic      empty,
  output bus_beat_t res_o
);

  back_state_e state_q, state_d, eff;
  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  bus_beat_t   out_q;
  bus_beat_t   beat;
  axis_job_t   ax;
  logic        load;

  assign empty = !out_valid_q;
  assign res_o = out_q;
  assign load  = job_valid_i && (!out_valid_q || pop);

  always_comb begin
    eff = state_q;
    if (eff == ST_COL && !job_i.col_chg) begin
      eff = ST_ROW;
    end
    if (eff == ST_ROW && !job_i.row_chg) begin
      eff = ST_RAM;
    end
  end

  // next state
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    job_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !pop;
    if (load) begin
      out_valid_d = 1'b1;
      if (eff == ST_RAM) begin
        job_pop_o = 1'b1;
        state_d   = ST_COL;
        idx_d     = '0;
      end else if (idx_q == LAST_IDX) begin
        idx_d   = '0;
        state_d = (eff == ST_COL) ? ST_ROW : ST_RAM;
      end else begin
        state_d = eff;
        idx_d   = idx_q + 3'd1;
      end
    end
  end

  // outputs
  always_comb begin
    ax              = (eff == ST_COL) ? job_i.col : job_i.row;
    beat.is_command = !idx_q[0];
    beat.last_word  = 1'b0;
    beat.bus_word   = '0;
    if (eff == ST_RAM) begin
      beat.is_command = 1'b1;
      beat.last_word  = 1'b1;
      beat.bus_word   = CMD_RAM_WRITE;
    end else begin
      case (idx_q[2:1])
        SEL_START: beat.bus_word = idx_q[0] ? ax.s : (ax.use_0408 ? CMD_VSTART : CMD_HSTART);
        SEL_END:   beat.bus_word = idx_q[0] ? ax.e : (ax.use_0408 ? CMD_VEND : CMD_HEND);
        SEL_POS:   beat.bus_word = idx_q[0] ? ax.p : (ax.use_0408 ? CMD_VPOS : CMD_HPOS);
        default:   beat.bus_word = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COL;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the LCD window command generator: directed table, then random windows.
module testbench import lwcg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CfgUnused    = 2'd3;
  localparam logic [1:0]  RotColMirror = 2'd1;
  localparam logic [1:0]  RotRowMirror = 2'd0;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned NumDir       = 23;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned PhaseItems   = 50;

  localparam bus_beat_t RamWriteBeat = '{1'b1, CMD_RAM_WRITE, 1'b1};

  typedef enum logic {
    EXP_PREDICT,
    EXP_RAM_ONLY
  } exp_kind_e;

  typedef struct packed {
    exp_kind_e kind;
    logic [1:0] rot;
    logic [7:0] coff;
    logic [7:0] roff;
    win_req_t   req;
  } dir_row_t;

  localparam dir_row_t DirTable [NumDir] = '{
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd0,   '{10'd0,    10'd0,    11'd1,    11'd1}},
    '{EXP_RAM_ONLY, 2'd0, 8'd0,   8'd0,   '{10'd0,    10'd0,    11'd1,    11'd1}},
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd0,   '{10'd1023, 10'd0,    11'd1024, 11'd1}},
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd0,   '{10'd1023, 10'd1023, 11'd1024, 11'd1024}},
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd0,   '{10'd0,    10'd0,    11'd0,    11'd0}},
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd0,   '{10'd1023, 10'd1023, 11'd2047, 11'd2047}},
    '{EXP_RAM_ONLY, 2'd0, 8'd0,   8'd0,   '{10'd1023, 10'd1023, 11'd2047, 11'd2047}},
    '{EXP_RAM_ONLY, 2'd1, 8'd255, 8'd255, '{10'd1023, 10'd1023, 11'd2047, 11'd2047}},
    '{EXP_PREDICT,  2'd1, 8'd255, 8'd255, '{10'd0,    10'd0,    11'd0,    11'd0}},
    '{EXP_PREDICT,  2'd1, 8'd255, 8'd255, '{10'd1023, 10'd0,    11'd1024, 11'd320}},
    '{EXP_PREDICT,  2'd1, 8'd255, 8'd255, '{10'd319,  10'd319,  11'd1,    11'd1}},
    '{EXP_RAM_ONLY, 2'd1, 8'd255, 8'd255, '{10'd319,  10'd319,  11'd1,    11'd1}},
    '{EXP_PREDICT,  2'd2, 8'd0,   8'd255, '{10'd0,    10'd0,    11'd320,  11'd240}},
    '{EXP_PREDICT,  2'd2, 8'd0,   8'd255, '{10'd1023, 10'd1023, 11'd2047, 11'd2047}},
    '{EXP_PREDICT,  2'd3, 8'd128, 8'd1,   '{10'd5,    10'd7,    11'd10,   11'd12}},
    '{EXP_PREDICT,  2'd3, 8'd128, 8'd1,   '{10'd5,    10'd8,    11'd10,   11'd12}},
    '{EXP_PREDICT,  2'd3, 8'd128, 8'd1,   '{10'd6,    10'd8,    11'd10,   11'd12}},
    '{EXP_PREDICT,  2'd3, 8'd128, 8'd1,   '{10'h2AA,  10'h155,  11'h555,  11'h2AA}},
    '{EXP_PREDICT,  2'd3, 8'd128, 8'd1,   '{10'h155,  10'h2AA,  11'h2AA,  11'h555}},
    '{EXP_PREDICT,  2'd0, 8'd255, 8'd0,   '{10'd1023, 10'd1023, 11'd1024, 11'd1024}},
    '{EXP_PREDICT,  2'd0, 8'd0,   8'd255, '{10'd320,  10'd320,  11'd0,    11'd1}},
    '{EXP_PREDICT,  2'd1, 8'd0,   8'd0,   '{10'd320,  10'd0,    11'd1,    11'd320}},
    '{EXP_RAM_ONLY, 2'd1, 8'd0,   8'd0,   '{10'd320,  10'd0,    11'd1,    11'd320}}
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_ROTATION;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       push        = 1'b0;
  logic       full;
  win_req_t   req_i       = '0;
  logic       pop         = 1'b0;
  logic       empty;
  bus_beat_t  res_o;

  logic [1:0]  rot_q     = 2'd0;
  logic [7:0]  col_off_q = 8'd0;
  logic [7:0]  row_off_q = 8'd0;
  logic [15:0] last_x    = '1;
  logic [15:0] last_w    = '1;
  logic [15:0] last_y    = '1;
  logic [15:0] last_h    = '1;

  bus_beat_t   pending_beats[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  lcd_window_command_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [10:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd1;
      3: return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic win_req_t random_window(input win_req_t prev);
    win_req_t r;
    r = prev;
    if ($urandom_range(0, 3) != 0) begin
      r.win_x     = pick_coord();
      r.win_width = pick_size();
    end
    if ($urandom_range(0, 3) != 0) begin
      r.win_y      = pick_coord();
      r.win_height = pick_size();
    end
    return r;
  endfunction

  task automatic add_axis_writes(input bit record, input bit use_0408, input bit mirror,
                                 input logic [15:0] c, input logic [15:0] size,
                                 input logic [15:0] off);
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] p;
    if (mirror) begin
      s = PanelHeight - c - size - off;
      e = PanelHeight - c - 16'd1 - off;
      p = e;
    end else begin
      s = c + off;
      e = c + size - 16'd1 + off;
      p = s;
    end
    if (record) begin
      pending_beats.push_back('{1'b1, use_0408 ? CMD_VSTART : CMD_HSTART, 1'b0});
      pending_beats.push_back('{1'b0, s, 1'b0});
      pending_beats.push_back('{1'b1, use_0408 ? CMD_VEND : CMD_HEND, 1'b0});
      pending_beats.push_back('{1'b0, e, 1'b0});
      pending_beats.push_back('{1'b1, use_0408 ? CMD_VPOS : CMD_HPOS, 1'b0});
      pending_beats.push_back('{1'b0, p, 1'b0});
    end
  endtask

  task automatic predict_window(input win_req_t r, input bit record);
    logic        landscape;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    landscape = rot_q[0];
    x = {6'd0, r.win_x};
    y = {6'd0, r.win_y};
    w = {5'd0, r.win_width};
    h = {5'd0, r.win_height};
    if (x != last_x || w != last_w) begin
      add_axis_writes(record, landscape, rot_q == RotColMirror, x, w, {8'd0, col_off_q});
      last_x = x;
      last_w = w;
    end
    if (y != last_y || h != last_h) begin
      add_axis_writes(record, !landscape, rot_q == RotRowMirror, y, h, {8'd0, row_off_q});
      last_y = y;
      last_h = h;
    end
    if (record) pending_beats.push_back(RamWriteBeat);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_ROTATION:   rot_q     = data[1:0];
      CFG_COL_OFFSET: col_off_q = data;
      CFG_ROW_OFFSET: row_off_q = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [1:0] rot, input logic [7:0] coff,
                           input logic [7:0] roff);
    write_reg(CFG_ROTATION, {6'($urandom_range(0, 63)), rot});
    write_reg(CFG_COL_OFFSET, coff);
    write_reg(CFG_ROW_OFFSET, roff);
    write_reg(CfgUnused, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_window(input win_req_t r, input exp_kind_e kind);
    int unsigned gap;
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    predict_window(r, kind == EXP_PREDICT);
    if (kind == EXP_RAM_ONLY) pending_beats.push_back(RamWriteBeat);
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    bus_beat_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending, word", res_o.bus_word, 0);
      end else begin
        want = pending_beats.pop_front();
        if (res_o.is_command !== want.is_command)
          report_mismatch("is_command", res_o.is_command, want.is_command);
        if (res_o.bus_word !== want.bus_word)
          report_mismatch("bus_word", res_o.bus_word, want.bus_word);
        if (res_o.last_word !== want.last_word)
          report_mismatch("last_word", res_o.last_word, want.last_word);
      end
    end
  end

  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      pop <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk_i);
      gap = gap_len();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    dir_row_t row;
    win_req_t prev;
    win_req_t next_req;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      row = DirTable[i];
      if (row.rot != rot_q || row.coff != col_off_q || row.roff != row_off_q) begin
        wait_drained();
        configure(row.rot, row.coff, row.roff);
      end
      send_window(row.req, row.kind);
    end
    prev = row.req;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      calm = (ph == 2);
      configure(2'(ph), pick_offset(), pick_offset());
      for (int k = 0; k < PhaseItems; k++) begin
        // hold the sender until the block has fully drained
        if (ph == 4 && k == PhaseItems / 2) wait_drained();
        next_req = random_window(prev);
        send_window(next_req, EXP_PREDICT);
        prev = next_req;
      end
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lwcg_pkg.sv
sv/lwcg_front.sv
sv/lwcg_fifo.sv
sv/lwcg_back.sv
sv/lcd_window_command_generator_top.sv
test/testbench.sv
